/* sv/wsfd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wsfd_pkg: shared types and constants of the frame decoder
// Beat types, parse phases, status codes and header field constants.
// ----------------------------------------------------------------------------
package wsfd_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam logic [3:0] OPCODE_TEXT  = 4'h1;
  localparam logic [6:0] LEN_EXT16    = 7'd126;
  localparam logic [6:0] LEN_EXT64    = 7'd127;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_PAY  = 3'd4,
    PH_DONE = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TRUNC   = 2'd1,
    ST_NOTTEXT = 2'd2,
    ST_LONG    = 2'd3
  } status_t;

  // input beat
  typedef struct packed {
    logic [7:0] in_byte;
    logic       buffer_end;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       status_valid;
    logic [1:0] status;
  } out_item_t;

  // classified beat, front to back
  typedef struct packed {
    logic       payload_valid;
    logic [7:0] data_byte;
    logic [7:0] key_byte;
    logic       status_valid;
    logic [1:0] status;
  } front_item_t;

endpackage : wsfd_pkg
`default_nettype wire

/* sv/wsfd_stream_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wsfd_stream_if: valid/ready stream channel
// Carries one payload beat of type T per handshake.
// ----------------------------------------------------------------------------
interface wsfd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface : wsfd_stream_if
`default_nettype wire

/* sv/wsfd_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wsfd_front: header parser
// Accepts input beats, tracks the frame header and classifies every beat
// as header, payload or trailing, with the key byte and status it needs.
// ----------------------------------------------------------------------------
module wsfd_front
  import wsfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  wsfd_stream_if.sink      bytes,
  output      logic        push,
  output      front_item_t push_item,
  input  wire logic        full
);

  phase_t      phase, phase_next;
  logic        mask_on, mask_on_next;
  logic [15:0] payload_length, payload_length_next;
  logic [15:0] payload_count, payload_count_next;
  logic [31:0] mask_key, mask_key_next;
  logic [1:0]  header_index, header_index_next;
  logic [1:0]  outcome, outcome_next;

  logic [7:0]  b;
  logic        last;
  logic [6:0]  len7;
  logic [7:0]  key_sel;
  logic        hdr_mask;
  logic [15:0] len_after;

  assign bytes.ready = !full;
  assign push        = bytes.valid && !full;
  assign b           = bytes.data.in_byte;
  assign last        = bytes.data.buffer_end;
  assign len7        = b[6:0];

  always_comb begin
    case (payload_count[1:0])
      2'd0:    key_sel = mask_key[31:24];
      2'd1:    key_sel = mask_key[23:16];
      2'd2:    key_sel = mask_key[15:8];
      default: key_sel = mask_key[7:0];
    endcase
  end

  always_comb begin
    phase_next          = phase;
    mask_on_next        = mask_on;
    payload_length_next = payload_length;
    payload_count_next  = payload_count;
    mask_key_next       = mask_key;
    header_index_next   = header_index;
    outcome_next        = outcome;
    push_item           = '0;
    hdr_mask            = 1'b0;
    len_after           = '0;

    unique case (phase)
      PH_HDR0: begin
        if (b[3:0] != OPCODE_TEXT) begin
          outcome_next = ST_NOTTEXT;
          phase_next   = PH_DONE;
        end else begin
          phase_next = PH_HDR1;
        end
      end
      PH_HDR1: begin
        hdr_mask           = b[7];
        mask_on_next       = hdr_mask;
        mask_key_next      = '0;
        payload_count_next = '0;
        if (len7 == LEN_EXT64) begin
          outcome_next = ST_LONG;
          phase_next   = PH_DONE;
        end else if (len7 == LEN_EXT16) begin
          payload_length_next = '0;
          header_index_next   = '0;
          phase_next          = PH_EXT;
        end else begin
          len_after           = {9'd0, len7};
          payload_length_next = len_after;
          header_index_next   = '0;
          if (hdr_mask) phase_next = PH_KEY;
          else phase_next = (len_after == 16'd0) ? PH_DONE : PH_PAY;
        end
      end
      PH_EXT: begin
        len_after           = {payload_length[7:0], b};
        payload_length_next = len_after;
        if (header_index == 2'd1) begin
          header_index_next = '0;
          if (mask_on) phase_next = PH_KEY;
          else phase_next = (len_after == 16'd0) ? PH_DONE : PH_PAY;
        end else begin
          header_index_next = 2'd1;
        end
      end
      PH_KEY: begin
        mask_key_next = {mask_key[23:0], b};
        if (header_index == 2'd3) begin
          header_index_next = '0;
          phase_next = (payload_length == 16'd0) ? PH_DONE : PH_PAY;
        end else begin
          header_index_next = header_index + 2'd1;
        end
      end
      PH_PAY: begin
        push_item.payload_valid = 1'b1;
        push_item.data_byte     = b;
        push_item.key_byte      = key_sel;
        payload_count_next      = payload_count + 16'd1;
        if (payload_count_next == payload_length) phase_next = PH_DONE;
      end
      default: ;  // finished or unused codes: trailing bytes ignored
    endcase

    if (last) begin
      push_item.status_valid = 1'b1;
      push_item.status       = (phase_next == PH_DONE) ? outcome_next : ST_TRUNC;
      phase_next             = PH_HDR0;
      mask_on_next           = 1'b0;
      payload_length_next    = '0;
      payload_count_next     = '0;
      mask_key_next          = '0;
      header_index_next      = '0;
      outcome_next           = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HDR0;
      mask_on        <= 1'b0;
      payload_length <= '0;
      payload_count  <= '0;
      mask_key       <= '0;
      header_index   <= '0;
      outcome        <= ST_OK;
    end else if (push) begin
      phase          <= phase_next;
      mask_on        <= mask_on_next;
      payload_length <= payload_length_next;
      payload_count  <= payload_count_next;
      mask_key       <= mask_key_next;
      header_index   <= header_index_next;
      outcome        <= outcome_next;
    end
  end

endmodule : wsfd_front
`default_nettype wire

/* sv/wsfd_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wsfd_queue: small FIFO between parser and output stage
// Register-based circular buffer of classified beats.
// ----------------------------------------------------------------------------
module wsfd_queue
  import wsfd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire front_item_t push_item,
  output      logic        full,
  input  wire logic        pop,
  output      front_item_t pop_item,
  output      logic        empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  front_item_t       entries [DEPTH];
  logic [AW-1:0]     wr_ptr, rd_ptr;
  logic [CW-1:0]     count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      if (pop)  rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
      if (push && !pop)      count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

endmodule : wsfd_queue
`default_nettype wire

/* sv/wsfd_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wsfd_back: unmask and output stage
// Pops classified beats, XORs payload bytes with their key byte and holds
// the result beat in an output register until taken.
// ----------------------------------------------------------------------------
module wsfd_back
  import wsfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        empty,
  input  wire front_item_t pop_item,
  output      logic        pop,
  wsfd_stream_if.source    results
);

  logic      out_valid;
  out_item_t out_item;

  assign pop           = !empty && (!out_valid || results.ready);
  assign results.valid = out_valid;
  assign results.data  = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item.payload_valid <= pop_item.payload_valid;
      out_item.payload_byte  <= pop_item.data_byte ^ pop_item.key_byte;
      out_item.status_valid  <= pop_item.status_valid;
      out_item.status        <= pop_item.status;
    end
  end

endmodule : wsfd_back
`default_nettype wire

/* sv/websocket_frame_decoder.sv */
`default_nettype none
// Path: an accepted input beat is written to the queue, then to the output
//   register. Throughput: 1 beat per cycle unless results stall, bounded
//   by the parser's one header/payload state update per byte; exactly one
//   result beat per input beat.
// Reset: synchronous, active high; parser returns to the first header byte,
//   queue and output register empty. No clearing pass.
// ----------------------------------------------------------------------------
// websocket_frame_decoder: first-frame decoder for a received buffer
// Parses the header of the buffer's first frame (text opcode only, 7-bit or
// 16-bit length, optional masking key), streams the payload unmasked and
// reports a status on the buffer's last byte.
// ----------------------------------------------------------------------------
module websocket_frame_decoder
  import wsfd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic     clk,
  input  wire logic     rst,
  wsfd_stream_if.sink   bytes,
  wsfd_stream_if.source results
);

  // Front to queue: one classified beat per accepted input beat. The front
  // stalls only when the queue is full.
  logic        push;
  front_item_t push_item;
  logic        full;

  // Queue to back: the back pops whenever its output register is free or
  // being emptied this cycle, so a depth of two keeps the input side ready
  // at full rate.
  logic        pop;
  front_item_t pop_item;
  logic        empty;

  wsfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .bytes     (bytes),
    .push      (push),
    .push_item (push_item),
    .full      (full)
  );

  wsfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (empty)
  );

  // Back: key XOR and the registered result beat.
  wsfd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .pop_item (pop_item),
    .pop      (pop),
    .results  (results)
  );

endmodule : websocket_frame_decoder
`default_nettype wire
